[rtl/msw_pkg.sv]
// Shared types and codes for the multi-slot task watchdog.
package msw_pkg;

    localparam int unsigned SLOT_W = 6;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned PER_W  = 16;

    localparam logic [PER_W-1:0] PERIOD_RESET = 16'd100;

    typedef enum logic [1:0] {
        OP_REG   = 2'd0,
        OP_FEED  = 2'd1,
        OP_STATS = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_REG   = 2'd0,
        KIND_FEED  = 2'd1,
        KIND_STATS = 2'd2,
        KIND_ALERT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic              used;
        logic [TIME_W-1:0] timeout;
        logic [TIME_W-1:0] last_feed;
    } slot_ent_t;

    typedef struct packed {
        logic      shift;
        slot_ent_t wb;
    } ring_ctl_t;

endpackage

[rtl/msw_cell.sv]
// One watchdog slot cell of the rotating ring.
module msw_cell
    import msw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  slot_ent_t         d_in,
    input  logic [TIME_W-1:0] time_now,
    output slot_ent_t         q,
    output logic              alert
);

    logic              used_reg;
    logic [TIME_W-1:0] timeout_reg;
    logic [TIME_W-1:0] feed_reg;
    logic [TIME_W-1:0] elapsed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (shift)
        begin
            used_reg <= d_in.used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            timeout_reg <= d_in.timeout;
            feed_reg    <= d_in.last_feed;
        end
    end

    assign elapsed     = time_now - feed_reg;
    assign alert       = used_reg && (elapsed > timeout_reg);
    assign q.used      = used_reg;
    assign q.timeout   = timeout_reg;
    assign q.last_feed = feed_reg;

endmodule

[rtl/msw_seq.sv]
// Sequencer: request decode, time keeping, ring stepping and result register.
module msw_seq
    import msw_pkg::*;
#(
    parameter int unsigned SLOTS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [PER_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  logic [SLOT_W-1:0] slot,
    input  logic [TIME_W-1:0] limit_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [1:0]        status,
    output logic [SLOT_W-1:0] slot_index,
    output logic [TIME_W-1:0] since_feed_ms,
    output logic [TIME_W-1:0] limit_reported_ms,
    output logic              last,
    input  slot_ent_t         head,
    input  logic              head_alert,
    input  logic              later_alert,
    output logic [TIME_W-1:0] time_now,
    output ring_ctl_t         ctl
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(SLOTS - 1);

    state_t            state_reg, state_next;
    logic [PER_W-1:0]  period_cfg_reg;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [PER_W-1:0]  pcount_reg, pcount_next;
    op_t               op_reg, op_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [TIME_W-1:0] limit_reg, limit_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [TIME_W-1:0] since_reg, since_next;
    logic [TIME_W-1:0] lim_reg, lim_next;

    logic              oval_reg, oval_next;
    logic [1:0]        okind_reg, okind_next;
    logic [1:0]        ostat_reg, ostat_next;
    logic [SLOT_W-1:0] oidx_reg, oidx_next;
    logic [TIME_W-1:0] osince_reg, osince_next;
    logic [TIME_W-1:0] olim_reg, olim_next;
    logic              olast_reg, olast_next;

    logic              accept;
    logic [PER_W-1:0]  pcount_inc;
    logic [TIME_W-1:0] head_el;
    logic              match;
    logic              hit;
    logic              emit;
    logic              out_free;
    logic              advance;
    logic              res_found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            period_cfg_reg <= PERIOD_RESET;
            time_reg       <= '0;
            pcount_reg     <= '0;
            step_reg       <= '0;
            found_reg      <= 1'b0;
            oval_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            time_reg   <= time_next;
            pcount_reg <= pcount_next;
            step_reg   <= step_next;
            found_reg  <= found_next;
            oval_reg   <= oval_next;
            if (cfg_we)
            begin
                period_cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        slot_reg   <= slot_next;
        limit_reg  <= limit_next;
        idx_reg    <= idx_next;
        since_reg  <= since_next;
        lim_reg    <= lim_next;
        okind_reg  <= okind_next;
        ostat_reg  <= ostat_next;
        oidx_reg   <= oidx_next;
        osince_reg <= osince_next;
        olim_reg   <= olim_next;
        olast_reg  <= olast_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign pcount_inc = pcount_reg + 1'b1;
    assign head_el    = time_reg - head.last_feed;
    assign match      = (SLOT_W'(step_reg) == slot_reg);
    assign out_free   = !oval_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        time_next   = time_reg;
        pcount_next = pcount_reg;
        op_next     = op_reg;
        slot_next   = slot_reg;
        limit_next  = limit_reg;
        step_next   = step_reg;
        found_next  = found_reg;
        idx_next    = idx_reg;
        since_next  = since_reg;
        lim_next    = lim_reg;

        oval_next   = oval_reg && out_stall;
        okind_next  = okind_reg;
        ostat_next  = ostat_reg;
        oidx_next   = oidx_reg;
        osince_next = osince_reg;
        olim_next   = olim_reg;
        olast_next  = olast_reg;

        case (op_reg)
            OP_REG:  hit = head.used ? 1'b0 : !found_reg;
            OP_TICK: hit = head_alert;
            default: hit = head.used && match;
        endcase

        emit      = (op_reg == OP_TICK) ? head_alert : (step_reg == LAST_STEP);
        advance   = (state_reg == ST_RUN) && (!emit || out_free);
        res_found = found_reg || hit;

        ctl.shift = advance;
        ctl.wb    = head;
        if (hit)
        begin
            case (op_reg)
                OP_REG:
                begin
                    ctl.wb.used      = 1'b1;
                    ctl.wb.timeout   = limit_reg;
                    ctl.wb.last_feed = time_reg;
                end
                OP_FEED, OP_TICK:
                begin
                    ctl.wb.last_feed = time_reg;
                end
                default:
                begin
                    ctl.wb = head;
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_t'(op);
                    slot_next  = slot;
                    limit_next = limit_ms;
                    step_next  = '0;
                    found_next = 1'b0;
                    if (op_t'(op) == OP_TICK)
                    begin
                        time_next = time_reg + 1'b1;
                        if ((pcount_inc >= period_cfg_reg) || (pcount_inc == '0))
                        begin
                            pcount_next = '0;
                            state_next  = ST_RUN;
                        end
                        else
                        begin
                            pcount_next = pcount_inc;
                        end
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    step_next = step_reg + 1'b1;
                    if (hit && (op_reg != OP_TICK))
                    begin
                        found_next = 1'b1;
                        idx_next   = step_reg;
                        since_next = head_el;
                        lim_next   = head.timeout;
                    end
                    if (emit)
                    begin
                        oval_next = 1'b1;
                        if (op_reg == OP_TICK)
                        begin
                            okind_next  = KIND_ALERT;
                            ostat_next  = STAT_OK;
                            oidx_next   = SLOT_W'(step_reg);
                            osince_next = head_el;
                            olim_next   = head.timeout;
                            olast_next  = !later_alert;
                        end
                        else
                        begin
                            okind_next  = op_reg;
                            olast_next  = 1'b1;
                            osince_next = '0;
                            olim_next   = '0;
                            oidx_next   = '0;
                            if (!res_found)
                            begin
                                ostat_next = (op_reg == OP_REG) ? STAT_FULL : STAT_BAD;
                            end
                            else
                            begin
                                ostat_next = STAT_OK;
                                oidx_next  = SLOT_W'(hit ? step_reg : idx_reg);
                                if (op_reg == OP_STATS)
                                begin
                                    osince_next = hit ? head_el : since_reg;
                                    olim_next   = hit ? head.timeout : lim_reg;
                                end
                            end
                        end
                    end
                    if (step_reg == LAST_STEP)
                    begin
                        step_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign time_now          = time_reg;
    assign out_valid         = oval_reg;
    assign kind              = okind_reg;
    assign status            = ostat_reg;
    assign slot_index        = oidx_reg;
    assign since_feed_ms     = osince_reg;
    assign limit_reported_ms = olim_reg;
    assign last              = olast_reg;

endmodule

[rtl/multi_slot_task_watchdog.sv]
// Top level: ring of watchdog slot cells with its sequencer.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   config  | in        | cfg_we              | cfg_wdata (check period, ms)
//   request | in        | in_valid / in_stall | op, slot, limit_ms
//   result  | out       | out_valid/out_stall | kind, status, slot_index, since_feed_ms,
//           |           |                     | limit_reported_ms, last
//
// A tick that does not scan only advances time and the period count. Register, feed, stats
// and scanning ticks rotate the slot ring once past the head cell, one slot a cycle.
// The ring stops for each cycle an alert or a reply waits on out_stall.
// Reset clears the used flags, time, period count and sets the period to 100 ms.
module multi_slot_task_watchdog
    import msw_pkg::*;
#(
    parameter int unsigned SLOTS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [PER_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  logic [SLOT_W-1:0] slot,
    input  logic [TIME_W-1:0] limit_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [1:0]        status,
    output logic [SLOT_W-1:0] slot_index,
    output logic [TIME_W-1:0] since_feed_ms,
    output logic [TIME_W-1:0] limit_reported_ms,
    output logic              last
);

    slot_ent_t         cell_q [SLOTS];
    logic [SLOTS-1:0]  cell_alert;
    logic [TIME_W-1:0] time_now;
    ring_ctl_t         ctl;
    logic              later_alert;

    assign later_alert = |(cell_alert >> 1);

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        slot_ent_t d_in;
        if (k == SLOTS - 1)
        begin : g_tail
            assign d_in = ctl.wb;
        end
        else
        begin : g_mid
            assign d_in = cell_q[k + 1];
        end
        msw_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (ctl.shift),
            .d_in     (d_in),
            .time_now (time_now),
            .q        (cell_q[k]),
            .alert    (cell_alert[k])
        );
    end

    msw_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .slot              (slot),
        .limit_ms          (limit_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .status            (status),
        .slot_index        (slot_index),
        .since_feed_ms     (since_feed_ms),
        .limit_reported_ms (limit_reported_ms),
        .last              (last),
        .head              (cell_q[0]),
        .head_alert        (cell_alert[0]),
        .later_alert       (later_alert),
        .time_now          (time_now),
        .ctl               (ctl)
    );

`ifndef SYNTHESIS
    a_shift_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift |-> in_stall)
        else $error("slot ring rotated while idle");

    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (op != OP_TICK)) |=> in_stall)
        else $error("request did not start a ring pass");

    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != KIND_ALERT)) |-> last)
        else $error("reply not marked last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STAT_OK)) |->
            ((slot_index == '0) && (since_feed_ms == '0) && (limit_reported_ms == '0)))
        else $error("error reply carries slot data");
`endif

endmodule
